FILE: rtl/core/utfd_pkg.sv
// Shared types, constants and helpers for the UTF-8 stream decoder.
// No dependencies; every other file of the block imports this package.
package utfd_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CNT_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int CP_W       = 31;
  localparam int OFF_W      = 16;
  localparam int RQ_DEPTH   = 4;
  localparam int RQ_AW      = $clog2(RQ_DEPTH);

  localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

  localparam logic [1:0] REG_CAPACITY = 2'd0;
  localparam logic [1:0] REG_VALIDATE = 2'd1;

  typedef enum logic [1:0] {
    ST_CHAR     = 2'd0,
    ST_DONE     = 2'd1,
    ST_INVALID  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    status_t          status;
    logic [15:0]      char_count;
    logic [OFF_W-1:0] error_offset;
    logic             last_result;
  } res_t;

  // Results produced by one byte, in delivery order.
  typedef struct packed {
    res_t       first;
    res_t       second;
    logic [1:0] num;
  } dec_out_t;

  // Clamp the character counter to the 16-bit reported field.
  function automatic logic [15:0] clamp_count(input logic [COUNT_BITS-1:0] c);
    logic [CNT_W-1:0] cw;
    cw = CNT_W'(c);
    if (cw > CNT_W'(16'hFFFF)) begin
      return 16'hFFFF;
    end
    return cw[15:0];
  endfunction

endpackage

FILE: rtl/core/utfd_if.sv
// Valid/ready channel interfaces for the decoder's byte input and result output.
// Depends on utfd_pkg for field widths.
interface utfd_str_if import utfd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface utfd_res_if import utfd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CP_W-1:0]  code_point;
  logic [1:0]       status;
  logic [15:0]      char_count;
  logic [OFF_W-1:0] error_offset;
  logic             last_result;

  modport source (output valid, output code_point, output status, output char_count,
                  output error_offset, output last_result, input ready);
  modport sink (input valid, input code_point, input status, input char_count,
                input error_offset, input last_result, output ready);
endinterface

FILE: rtl/core/utf8_stream_decoder.sv
// UTF-8 stream decoder, six-byte form: one byte per transaction in, results out.
// A byte's results are registered in the result queue and offered from its head.
// Throughput: one byte per cycle; the input stalls while the four-entry result queue
// holds more than two results, so a run of bytes that each end a string with a character
// (two results each) cannot keep that rate. Reset clears all string state and the queue,
// sets out_capacity to 65535 and validate_only to 0. Uses utfd_* files.
module utf8_stream_decoder import utfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  utfd_str_if.sink    str,
  utfd_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] out_capacity;
  logic        validate_only;
  logic        cfg_wr;
  logic [1:0]  reg_sel;
  logic        accept;
  logic        room;
  dec_out_t    dout;
  dec_out_t    push;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign reg_sel = {1'b0, paddr[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity  <= 16'hFFFF;
      validate_only <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_CAPACITY: out_capacity  <= pwdata[15:0];
        REG_VALIDATE: validate_only <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CAPACITY: prdata = {16'h0000, out_capacity};
      REG_VALIDATE: prdata = {31'h0, validate_only};
      default:      prdata = '0;
    endcase
  end

  assign str.ready = room;
  assign accept    = str.valid & room;

  utfd_dec u_dec (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (str.in_byte),
    .end_of_string (str.end_of_string),
    .out_capacity  (out_capacity),
    .validate_only (validate_only),
    .dout          (dout)
  );

  always_comb begin
    push = dout;
    if (!accept) begin
      push.num = 2'd0;
    end
  end

  utfd_rq u_rq (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .res  (res)
  );

endmodule

FILE: rtl/core/utfd_dec.sv
// Per-byte UTF-8 decode step: sequence state registers and result generation.
// Depends on utfd_pkg.
module utfd_dec import utfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        end_of_string,
  input  logic [15:0] out_capacity,
  input  logic        validate_only,
  output dec_out_t    dout
);

  logic [2:0]            bytes_pending, bytes_pending_next;
  logic [CP_W-1:0]       partial_value, partial_value_next;
  logic [COUNT_BITS-1:0] chars_done, chars_done_next;
  logic [OFF_W-1:0]      byte_offset, byte_offset_next;
  logic [OFF_W-1:0]      sequence_start, sequence_start_next;
  logic                  failed, failed_next;

  logic             err;
  status_t          err_code;
  logic [OFF_W-1:0] err_off;
  logic [15:0]      cnt;
  res_t             done_res;
  res_t             char_res;

  always_comb begin
    bytes_pending_next  = bytes_pending;
    partial_value_next  = partial_value;
    chars_done_next     = chars_done;
    byte_offset_next    = (byte_offset != OFF_MAX) ? byte_offset + 1'b1 : byte_offset;
    sequence_start_next = sequence_start;
    failed_next         = failed;
    err                 = 1'b0;
    err_code            = ST_INVALID;
    err_off             = '0;

    if (bytes_pending == 3'd0) begin
      sequence_start_next = byte_offset;
      err_off             = byte_offset;
      priority if (!validate_only && (CNT_W'(chars_done) >= CNT_W'(out_capacity))) begin
        err      = 1'b1;
        err_code = ST_OVERFLOW;
      end else if (in_byte[7] == 1'b0) begin
        partial_value_next = CP_W'(in_byte);
      end else if (in_byte[7:5] == 3'b110) begin
        bytes_pending_next = 3'd1;
        partial_value_next = CP_W'(in_byte[4:0]);
      end else if (in_byte[7:4] == 4'b1110) begin
        bytes_pending_next = 3'd2;
        partial_value_next = CP_W'(in_byte[3:0]);
      end else if (in_byte[7:3] == 5'b11110) begin
        bytes_pending_next = 3'd3;
        partial_value_next = CP_W'(in_byte[2:0]);
      end else if (in_byte[7:2] == 6'b111110) begin
        bytes_pending_next = 3'd4;
        partial_value_next = CP_W'(in_byte[1:0]);
      end else if (in_byte[7:1] == 7'b1111110) begin
        bytes_pending_next = 3'd5;
        partial_value_next = CP_W'(in_byte[0]);
      end else begin
        err = 1'b1;
      end
    end else if (in_byte[7:6] != 2'b10) begin
      err     = 1'b1;
      err_off = sequence_start;
    end else begin
      partial_value_next = {partial_value[CP_W-7:0], in_byte[5:0]};
      bytes_pending_next = bytes_pending - 3'd1;
    end

    if (!err && (bytes_pending_next == 3'd0) && !(&chars_done)) begin
      chars_done_next = chars_done + 1'b1;
    end
    cnt = clamp_count(chars_done_next);

    char_res = '{code_point: partial_value_next, status: ST_CHAR, char_count: cnt,
                 error_offset: '0, last_result: 1'b0};
    done_res = '{code_point: '0, status: ST_DONE, char_count: cnt,
                 error_offset: '0, last_result: 1'b1};

    dout = '{first: char_res, second: done_res, num: 2'd0};
    if (failed) begin
      dout.num = 2'd0;
    end else if (err) begin
      dout.first = '{code_point: '0, status: err_code, char_count: cnt,
                     error_offset: err_off, last_result: 1'b1};
      dout.num   = 2'd1;
      failed_next = 1'b1;
    end else if (bytes_pending_next == 3'd0) begin
      // Validate mode drops the character result and keeps only the total.
      if (validate_only) begin
        dout.first = done_res;
        dout.num   = end_of_string ? 2'd1 : 2'd0;
      end else begin
        dout.num = end_of_string ? 2'd2 : 2'd1;
      end
    end else if (end_of_string) begin
      // Sequence cut short by the end of the string.
      dout.first = '{code_point: '0, status: ST_INVALID, char_count: cnt,
                     error_offset: sequence_start_next, last_result: 1'b1};
      dout.num   = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_pending  <= '0;
      partial_value  <= '0;
      chars_done     <= '0;
      byte_offset    <= '0;
      sequence_start <= '0;
      failed         <= 1'b0;
    end else if (accept) begin
      if (end_of_string) begin
        bytes_pending  <= '0;
        partial_value  <= '0;
        chars_done     <= '0;
        byte_offset    <= '0;
        sequence_start <= '0;
        failed         <= 1'b0;
      end else if (!failed) begin
        bytes_pending  <= bytes_pending_next;
        partial_value  <= partial_value_next;
        chars_done     <= chars_done_next;
        byte_offset    <= byte_offset_next;
        sequence_start <= sequence_start_next;
        failed         <= failed_next;
      end
    end
  end

endmodule

FILE: rtl/core/utfd_rq.sv
// Four-entry result queue that takes up to two results per cycle and sends one.
// Depends on utfd_pkg and the result channel interface.
module utfd_rq import utfd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dec_out_t  push,
  output logic      room,
  utfd_res_if.source res
);

  res_t             mem [RQ_DEPTH];
  logic [RQ_AW-1:0] wp, rp;
  logic [RQ_AW:0]   count, count_next;
  logic             pop;
  res_t             head;

  assign pop  = res.valid & res.ready;
  assign room = count <= (RQ_AW + 1)'(RQ_DEPTH - 2);
  assign head = mem[rp];

  assign res.valid        = count != '0;
  assign res.code_point   = head.code_point;
  assign res.status       = head.status;
  assign res.char_count   = head.char_count;
  assign res.error_offset = head.error_offset;
  assign res.last_result  = head.last_result;

  assign count_next = count + (RQ_AW + 1)'(push.num) - (RQ_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + RQ_AW'(push.num);
      rp    <= rp + RQ_AW'(pop);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wp] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[wp + RQ_AW'(1)] <= push.second;
    end
  end

endmodule

FILE: tb/utf8_stream_decoder_tb.sv
// Self-checking testbench for utf8_stream_decoder: directed byte strings, then random strings.
// Results are checked against a predictor of the decoder. Uses utfd_pkg and utfd_if.
module utf8_stream_decoder_tb;
  import utfd_pkg::*;

  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned HOLD_CYCLES    = 64;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned RANDOM_ITEMS   = 1250;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef enum logic {ROW_BYTE, ROW_WRITE} row_kind_t;

  typedef struct {
    logic known;
    res_t res;
  } pinned_t;

  typedef struct {
    row_kind_t   kind;
    logic [7:0]  b;
    logic        eos;
    logic        known;
    res_t        res;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  utfd_str_if str_ch ();
  utfd_res_if res_ch ();

  utf8_stream_decoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .str     (str_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Decoder state as predicted, plus the register copies.
  logic [2:0]            dec_pending;
  logic [CP_W-1:0]       dec_value;
  logic [COUNT_BITS-1:0] dec_chars;
  logic [OFF_W-1:0]      dec_offset;
  logic [OFF_W-1:0]      dec_lead_at;
  logic                  dec_failed;
  logic [15:0]           reg_capacity;
  logic                  reg_validate;

  res_t    expected_results[$];
  pinned_t pinned_q[$];
  row_t    script[$];

  bit          tx_gaps;
  bit          rx_gaps;
  bit          rx_hold_request;
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned strings_sent;
  int unsigned results_checked;
  int unsigned status_seen[4];
  int unsigned idle_cycles;

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("MISMATCH: %s", msg);
    end
  endfunction

  function automatic void clear_string();
    dec_pending = '0;
    dec_value   = '0;
    dec_chars   = '0;
    dec_offset  = '0;
    dec_lead_at = '0;
    dec_failed  = 1'b0;
  endfunction

  function automatic res_t result_of(input logic [CP_W-1:0] cp, input status_t st,
                                     input logic [OFF_W-1:0] off, input logic last);
    res_t r;
    logic [63:0] c64;
    c64 = 64'(dec_chars);
    r.code_point   = cp;
    r.status       = st;
    r.char_count   = (c64 > 64'hFFFF) ? 16'hFFFF : c64[15:0];
    r.error_offset = off;
    r.last_result  = last;
    return r;
  endfunction

  // Advances the predicted state by one byte and queues the results it causes.
  function automatic int unsigned predict_decode(input logic [7:0] b, input logic eos);
    logic [OFF_W-1:0] cur;
    logic [OFF_W-1:0] err_off;
    status_t          err;
    logic             bad;
    int unsigned      n;
    cur     = dec_offset;
    err     = ST_INVALID;
    err_off = '0;
    bad     = 1'b0;
    n       = 0;
    if (dec_failed) begin
      if (eos) clear_string();
      return 0;
    end
    if (dec_offset != OFF_MAX) dec_offset++;

    if (dec_pending == 0) begin
      dec_lead_at = cur;
      if (!reg_validate && 64'(dec_chars) >= 64'(reg_capacity)) begin
        bad = 1'b1; err = ST_OVERFLOW; err_off = cur;
      end else if (b[7] == 1'b0) begin
        dec_value = CP_W'(b);
      end else if (b[7:5] == 3'b110) begin
        dec_pending = 3'd1; dec_value = CP_W'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        dec_pending = 3'd2; dec_value = CP_W'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        dec_pending = 3'd3; dec_value = CP_W'(b[2:0]);
      end else if (b[7:2] == 6'b111110) begin
        dec_pending = 3'd4; dec_value = CP_W'(b[1:0]);
      end else if (b[7:1] == 7'b1111110) begin
        dec_pending = 3'd5; dec_value = CP_W'(b[0]);
      end else begin
        bad = 1'b1; err_off = cur;
      end
    end else if (b[7:6] != 2'b10) begin
      bad = 1'b1; err_off = dec_lead_at;
    end else begin
      dec_value   = {dec_value[CP_W-7:0], b[5:0]};
      dec_pending = dec_pending - 3'd1;
    end

    if (bad) begin
      expected_results.push_back(result_of('0, err, err_off, 1'b1));
      if (eos) clear_string();
      else dec_failed = 1'b1;
      return 1;
    end

    if (dec_pending == 0) begin
      if (dec_chars != '1) dec_chars++;
      if (!reg_validate) begin
        expected_results.push_back(result_of(dec_value, ST_CHAR, '0, 1'b0));
        n++;
      end
    end else if (eos) begin
      // The string ended in the middle of a multi-byte sequence.
      expected_results.push_back(result_of('0, ST_INVALID, dec_lead_at, 1'b1));
      clear_string();
      return n + 1;
    end

    if (eos) begin
      expected_results.push_back(result_of('0, ST_DONE, '0, 1'b1));
      clear_string();
      n++;
    end
    return n;
  endfunction

  always @(posedge clk) begin : result_compare
    res_t        got;
    res_t        want;
    pinned_t     pin;
    int unsigned n;
    bit          busy;
    if (rst) begin
      clear_string();
      reg_capacity = 16'hFFFF;
      reg_validate = 1'b0;
      expected_results.delete();
      pinned_q.delete();
      idle_cycles = 0;
    end else begin
      busy = 1'b0;
      if (res_ch.valid && res_ch.ready) begin
        busy                = 1'b1;
        got.code_point   = res_ch.code_point;
        got.status       = status_t'(res_ch.status);
        got.char_count   = res_ch.char_count;
        got.error_offset = res_ch.error_offset;
        got.last_result  = res_ch.last_result;
        results_checked++;
        status_seen[res_ch.status]++;
        if (expected_results.size() == 0) begin
          note_error($sformatf("unexpected result cp=%0h status=%0d count=%0d off=%0d last=%0b",
                               got.code_point, got.status, got.char_count,
                               got.error_offset, got.last_result));
        end else begin
          want = expected_results.pop_front();
          if (got.code_point !== want.code_point || got.status !== want.status ||
              got.char_count !== want.char_count || got.error_offset !== want.error_offset ||
              got.last_result !== want.last_result) begin
            note_error($sformatf({"expected cp=%0h status=%0d count=%0d off=%0d last=%0b, ",
                                  "got cp=%0h status=%0d count=%0d off=%0d last=%0b"},
                                 want.code_point, want.status, want.char_count,
                                 want.error_offset, want.last_result,
                                 got.code_point, got.status, got.char_count,
                                 got.error_offset, got.last_result));
          end
        end
      end

      if (str_ch.valid && str_ch.ready) begin
        busy = 1'b1;
        pin  = pinned_q.pop_front();
        n    = predict_decode(str_ch.in_byte, str_ch.end_of_string);
        // Directed rows with a hand-written result replace the first prediction.
        if (pin.known && n > 0) begin
          expected_results[expected_results.size() - n] = pin.res;
        end
      end

      if (psel && penable) begin
        busy = 1'b1;
        if (pwrite && pready) begin
          case (2'(paddr >> 2))
            REG_CAPACITY: reg_capacity = pwdata[15:0];
            REG_VALIDATE: reg_validate = pwdata[0];
            default: ;
          endcase
        end
      end

      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : result_sink
    int unsigned gap;
    res_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_request) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold_request = 1'b0;
      end else begin
        gap = rx_gaps ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
          res_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= 3'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [31:0] rd;
    logic [31:0] want;
    apb_access(1'b0, idx, '0, rd);
    want = (idx == REG_CAPACITY) ? 32'(reg_capacity) : 32'(reg_validate);
    if (rd !== want) begin
      note_error($sformatf("register %0d read %0h, expected %0h", idx, rd, want));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    logic [31:0] rd;
    apb_access(1'b1, idx, 32'(value), rd);
    check_reg(idx);
  endtask

  // Stops offering bytes and waits until the decoder has nothing left to deliver.
  task automatic settle();
    str_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic eos, input logic known,
                           input res_t res);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      str_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pinned_q.push_back('{known: known, res: res});
    str_ch.valid         <= 1'b1;
    str_ch.in_byte       <= b;
    str_ch.end_of_string <= eos;
    @(posedge clk);
    while (!str_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    if (eos) strings_sent++;
  endtask

  task automatic send_string(ref logic [7:0] q[$]);
    foreach (q[i]) send_byte(q[i], (i == q.size() - 1), 1'b0, '0);
  endtask

  function automatic void push_char(ref logic [7:0] q[$], input int unsigned len);
    logic [7:0] lead;
    case (len)
      1:       lead = 8'($urandom_range(0, 127));
      2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
      3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
      4:       lead = 8'hF0 | 8'($urandom_range(0, 7));
      5:       lead = 8'hF8 | 8'($urandom_range(0, 3));
      default: lead = 8'hFC | 8'($urandom_range(0, 1));
    endcase
    q.push_back(lead);
    repeat (len - 1) q.push_back(8'h80 | 8'($urandom_range(0, 63)));
  endfunction

  // Mostly well-formed strings; some are cut short or corrupted, a few are pure noise.
  function automatic void build_string(ref logic [7:0] q[$]);
    int unsigned kind;
    int unsigned len;
    int unsigned pick;
    int unsigned pos;
    q.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      repeat ($urandom_range(1, 8)) q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(1, 10)) begin
      pick = $urandom_range(0, 9);
      len  = (pick < 4) ? 1 : (pick < 6) ? 2 : pick - 3;
      push_char(q, len);
    end
    if (kind >= 75) begin
      pos = $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 2))
        0: begin
          len = $urandom_range(2, 6);
          push_char(q, len);
          repeat ($urandom_range(1, len - 1)) void'(q.pop_back());
        end
        1: q[pos] = 8'($urandom_range(0, 255));
        default: q[pos] = $urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                               : 8'($urandom_range(8'hFE, 8'hFF));
      endcase
    end
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic eos);
    script.push_back('{kind: ROW_BYTE, b: b, eos: eos, known: 1'b0, res: '0,
                       reg_idx: '0, reg_val: '0});
  endfunction

  function automatic void add_checked(input logic [7:0] b, input logic eos, input status_t st,
                                      input int unsigned cnt, input int unsigned off);
    res_t r;
    r.code_point   = '0;
    r.status       = st;
    r.char_count   = 16'(cnt);
    r.error_offset = 16'(off);
    r.last_result  = (st != ST_CHAR);
    script.push_back('{kind: ROW_BYTE, b: b, eos: eos, known: 1'b1, res: r,
                       reg_idx: '0, reg_val: '0});
  endfunction

  function automatic void add_write(input logic [1:0] idx, input logic [15:0] value);
    script.push_back('{kind: ROW_WRITE, b: '0, eos: 1'b0, known: 1'b0, res: '0,
                       reg_idx: idx, reg_val: value});
  endfunction

  initial begin : stimulus
    logic [7:0]  text[$];
    logic [15:0] cap;
    logic        val;
    int unsigned phase_start;
    str_ch.valid         = 1'b0;
    str_ch.in_byte       = '0;
    str_ch.end_of_string = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    tx_gaps              = 1'b1;
    rx_gaps              = 1'b1;
    rx_hold_request      = 1'b0;

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    check_reg(REG_CAPACITY);
    check_reg(REG_VALIDATE);

    // Largest code point in the six-byte form, then done on the same byte.
    add_checked(8'h00, 1'b0, ST_CHAR, 1, 0);
    add_byte(8'hFD, 1'b0);
    repeat (4) add_byte(8'hBF, 1'b0);
    add_byte(8'hBF, 1'b1);
    // Bad lead bytes; the rest of a failed string is swallowed.
    add_checked(8'hFF, 1'b1, ST_INVALID, 0, 0);
    add_checked(8'h80, 1'b0, ST_INVALID, 0, 0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h41, 1'b1);
    // Bad continuation reports the offset of its lead byte.
    add_byte(8'h41, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_checked(8'h41, 1'b0, ST_INVALID, 1, 1);
    add_byte(8'h00, 1'b1);
    // Sequence cut short by the end of the string.
    add_byte(8'hF0, 1'b0);
    add_checked(8'h9F, 1'b1, ST_INVALID, 0, 0);
    // Capacity lowered in the middle of a string.
    add_byte(8'h41, 1'b0);
    add_byte(8'hC3, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_write(REG_CAPACITY, 16'd2);
    add_checked(8'h7E, 1'b1, ST_OVERFLOW, 2, 3);
    add_write(REG_CAPACITY, 16'd0);
    add_checked(8'h41, 1'b1, ST_OVERFLOW, 0, 0);
    // Validate mode ignores the capacity and only reports the total.
    add_write(REG_VALIDATE, 16'd1);
    add_byte(8'h41, 1'b0);
    add_byte(8'hE2, 1'b0);
    add_byte(8'h82, 1'b0);
    add_checked(8'hAC, 1'b1, ST_DONE, 2, 0);
    add_write(REG_VALIDATE, 16'd0);
    add_write(REG_CAPACITY, 16'hFFFF);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        settle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        send_byte(script[i].b, script[i].eos, script[i].known, script[i].res);
      end
    end

    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       begin cap = 16'hFFFF;                        val = 1'b0; end
        1:       begin cap = 16'd3;                           val = 1'b0; end
        2:       begin cap = 16'd0;                           val = 1'b0; end
        3:       begin cap = 16'hFFFF;                        val = 1'b1; end
        4:       begin cap = 16'($urandom_range(1, 12));      val = 1'b0; end
        5:       begin cap = 16'($urandom_range(0, 16'hFFFF)); val = 1'b1; end
        6:       begin cap = 16'd8;                           val = 1'b0; end
        default: begin cap = 16'($urandom_range(0, 16'hFFFF)); val = 1'b0; end
      endcase
      write_reg(REG_CAPACITY, cap);
      write_reg(REG_VALIDATE, 16'(val));
      tx_gaps = (p % 3 != 1);
      rx_gaps = (p % 3 != 2);
      if (p == 4) begin
        // Back-to-back bytes against a stalled output fill the result queue.
        tx_gaps         = 1'b0;
        rx_hold_request = 1'b1;
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < RANDOM_ITEMS / PHASES) begin
        build_string(text);
        send_string(text);
        if (p == 4 && !rx_hold_request) tx_gaps = 1'b1;
        if ($urandom_range(0, 19) == 0) settle();
      end
    end

    settle();
    $display("Run covered %0d strings and %0d bytes; %0d results checked.",
             strings_sent, bytes_sent, results_checked);
    $display("Results by status: char %0d, done %0d, invalid %0d, overflow %0d; mismatches %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
